// ----- rtl/mss_pkg.sv -----
`timescale 1ns / 1ps

package mss_pkg;

    localparam int ADC_BITS  = 10;
    localparam int TIME_BITS = 16;

    localparam int IVL_W     = 16;
    localparam int CAL_W     = ADC_BITS + 1;
    localparam int SUM_W     = 16;
    localparam int CNT_W     = 16;
    localparam int PCT_W     = 8;
    localparam int PCT_SCALE = 100;
    localparam int NUM_W     = CAL_W + 7;
    localparam int DIV_W     = (NUM_W > SUM_W) ? NUM_W : SUM_W;
    localparam int DEN_W     = (CAL_W > CNT_W) ? CAL_W : CNT_W;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    localparam int ACC_W     = ((IVL_W > TIME_BITS) ? IVL_W : TIME_BITS) + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int NUM_PCTS  = 4;
    localparam int PCT_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_READING_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DRY_RAW          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WET_RAW          = 3'd4;

    localparam logic [IVL_W-1:0] RESET_READING_INTERVAL = IVL_W'(15000);
    localparam logic [IVL_W-1:0] RESET_POLL_INTERVAL    = IVL_W'(100);
    localparam logic [IVL_W-1:0] RESET_WINDOW_LENGTH    = IVL_W'(1000);
    localparam logic [CAL_W-1:0] RESET_DRY_RAW          = CAL_W'(1 << ADC_BITS);
    localparam logic [CAL_W-1:0] RESET_WET_RAW          = CAL_W'(350);
    localparam logic [IVL_W-1:0] RESET_WAIT_ELAPSED     = IVL_W'(15000);
    localparam logic [CAL_W-1:0] RESET_LOWEST_RAW       = CAL_W'(1 << ADC_BITS);
    localparam logic [CNT_W-1:0] COUNT_MAX              = {CNT_W{1'b1}};
    localparam logic [PCT_W-1:0] PCT_MAX                = {PCT_W{1'b1}};

    localparam logic [PCT_IDX_W-1:0] PCT_CURRENT = 2'd0;
    localparam logic [PCT_IDX_W-1:0] PCT_AVERAGE = 2'd1;
    localparam logic [PCT_IDX_W-1:0] PCT_WETTEST = 2'd2;
    localparam logic [PCT_IDX_W-1:0] PCT_DRIEST  = 2'd3;

    typedef struct packed {
        logic [IVL_W-1:0] reading_interval;
        logic [IVL_W-1:0] poll_interval;
        logic [IVL_W-1:0] window_length;
        logic [CAL_W-1:0] dry_raw;
        logic [CAL_W-1:0] wet_raw;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic             zero;
        logic [NUM_W-1:0] num;
        logic [CAL_W-1:0] den;
    } pct_op_t;

    // Percent map operands: the quotient is formed on magnitudes. A result that
    // would be negative, or a zero span between dry and wet, forces zero.
    function automatic pct_op_t pct_prep(input logic [CAL_W-1:0] x,
                                         input logic [CAL_W-1:0] dry,
                                         input logic [CAL_W-1:0] wet);
        logic [CAL_W:0]   d;
        logic [CAL_W:0]   den;
        logic [CAL_W:0]   neg_d;
        logic [CAL_W:0]   neg_den;
        logic [CAL_W-1:0] mag_d;
        pct_op_t          r;
        d       = {1'b0, x} - {1'b0, dry};
        den     = {1'b0, wet} - {1'b0, dry};
        neg_d   = -d;
        neg_den = -den;
        mag_d   = d[CAL_W] ? neg_d[CAL_W-1:0] : d[CAL_W-1:0];
        r.den   = den[CAL_W] ? neg_den[CAL_W-1:0] : den[CAL_W-1:0];
        r.zero  = (den == '0) || (d[CAL_W] != den[CAL_W]);
        r.num   = NUM_W'(mag_d) * NUM_W'(PCT_SCALE);
        return r;
    endfunction

    function automatic logic [PCT_W-1:0] pct_sat(input logic [DIV_W-1:0] q);
        logic [PCT_W-1:0] r;
        r = (|q[DIV_W-1:PCT_W]) ? PCT_MAX : q[PCT_W-1:0];
        return r;
    endfunction

endpackage

// ----- rtl/mss_in_if.sv -----
`timescale 1ns / 1ps

interface mss_in_if;
    import mss_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] elapsed_ms;
    logic [ADC_BITS-1:0]  adc_sample;

    modport source (output valid, output elapsed_ms, output adc_sample, input ready);
    modport sink   (input valid, input elapsed_ms, input adc_sample, output ready);
endinterface

// ----- rtl/mss_out_if.sv -----
`timescale 1ns / 1ps

interface mss_out_if;
    import mss_pkg::*;

    logic             valid;
    logic             ready;
    logic             sensor_power;
    logic             new_result;
    logic [PCT_W-1:0] current_pct;
    logic [PCT_W-1:0] average_pct;
    logic [PCT_W-1:0] wettest_pct;
    logic [PCT_W-1:0] driest_pct;

    modport source (output valid, output sensor_power, output new_result,
                    output current_pct, output average_pct, output wettest_pct,
                    output driest_pct, input ready);
    modport sink   (input valid, input sensor_power, input new_result,
                    input current_pct, input average_pct, input wettest_pct,
                    input driest_pct, output ready);
endinterface

// ----- rtl/moisture_sampling_sequencer.sv -----
`timescale 1ns / 1ps

// Each tick beat after the boot beat updates the wait timer, or the poll and
// window timers, in the cycle it is accepted; its result beat then passes
// through S_EMIT into the output register, waiting there while a held beat
// is not yet taken. A tick that closes a window runs one shared 18-step
// serial divider up to five times in turn: once for the window average when
// samples were taken, then once for each of the four percent values;
// tick.ready is low while this work is in progress. The output register holds
// a finished beat, so the next tick is taken while it waits for report.ready.
module moisture_sampling_sequencer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [mss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mss_pkg::CFG_DATA_W-1:0] cfg_data,
    mss_in_if.sink                         tick,
    mss_out_if.source                      report
);
    import mss_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_AVG,
        S_PCT,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_BOOT,
        PH_WAIT,
        PH_POLL
    } phase_t;

    cfg_t     cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;
    pct_op_t  pct_op;

    state_t               state_reg, state_next;
    phase_t               phase_reg, phase_next;
    logic [IVL_W-1:0]     wait_reg, wait_next;
    logic [IVL_W-1:0]     poll_reg, poll_next;
    logic [IVL_W-1:0]     win_reg, win_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [ADC_BITS-1:0]  last_reg, last_next;
    logic [ADC_BITS-1:0]  avg_reg, avg_next;
    logic [CAL_W-1:0]     low_reg, low_next;
    logic [ADC_BITS-1:0]  high_reg, high_next;
    logic                 power_reg, power_next;
    logic                 nres_reg, nres_next;
    logic [PCT_W-1:0]     pct_reg [NUM_PCTS];
    logic [PCT_W-1:0]     pct_next [NUM_PCTS];
    logic [PCT_IDX_W-1:0] idx_reg, idx_next;
    logic                 run_reg, run_next;
    logic                 zero_reg, zero_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_power_reg, out_power_next;
    logic                 out_nres_reg, out_nres_next;
    logic [PCT_W-1:0]     out_pct_reg [NUM_PCTS];
    logic [PCT_W-1:0]     out_pct_next [NUM_PCTS];

    logic [ACC_W-1:0]     wait_sum, poll_sum, win_sum;
    logic                 wait_due, poll_due, win_due;
    logic [CNT_W-1:0]     cnt_smp;
    logic [SUM_W-1:0]     sum_smp;
    logic [CAL_W-1:0]     pct_x;

    mss_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mss_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign wait_sum = ACC_W'(wait_reg) + ACC_W'(tick.elapsed_ms);
    assign poll_sum = ACC_W'(poll_reg) + ACC_W'(tick.elapsed_ms);
    assign win_sum  = ACC_W'(win_reg) + ACC_W'(tick.elapsed_ms);
    assign wait_due = wait_sum >= ACC_W'(cfg.reading_interval);
    assign poll_due = poll_sum >= ACC_W'(cfg.poll_interval);
    assign win_due  = win_sum >= ACC_W'(cfg.window_length);

    assign cnt_smp = (poll_due && (cnt_reg != COUNT_MAX)) ? cnt_reg + 1'b1 : cnt_reg;
    assign sum_smp = poll_due ? sum_reg + SUM_W'(tick.adc_sample) : sum_reg;

    always_comb
    begin
        case (idx_reg)
            PCT_CURRENT: pct_x = CAL_W'(last_reg);
            PCT_AVERAGE: pct_x = CAL_W'(avg_reg);
            PCT_WETTEST: pct_x = low_reg;
            default:     pct_x = CAL_W'(high_reg);
        endcase
    end

    assign pct_op = pct_prep(pct_x, cfg.dry_raw, cfg.wet_raw);

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        wait_next      = wait_reg;
        poll_next      = poll_reg;
        win_next       = win_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        last_next      = last_reg;
        avg_next       = avg_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        power_next     = power_reg;
        nres_next      = nres_reg;
        pct_next       = pct_reg;
        idx_next       = idx_reg;
        run_next       = run_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg && !report.ready;
        out_power_next = out_power_reg;
        out_nres_next  = out_nres_reg;
        out_pct_next   = out_pct_reg;
        div_req        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (tick.valid)
                begin
                    state_next = S_EMIT;
                    nres_next  = 1'b0;
                    case (phase_reg)
                        PH_BOOT:
                        begin
                            last_next  = tick.adc_sample;
                            phase_next = PH_WAIT;
                        end
                        PH_POLL:
                        begin
                            poll_next = poll_due ? '0 : poll_sum[IVL_W-1:0];
                            win_next  = win_due ? '0 : win_sum[IVL_W-1:0];
                            cnt_next  = cnt_smp;
                            sum_next  = sum_smp;
                            if (poll_due)
                            begin
                                last_next = tick.adc_sample;
                                if (CAL_W'(tick.adc_sample) < low_reg)
                                begin
                                    low_next = CAL_W'(tick.adc_sample);
                                end
                                if (tick.adc_sample > high_reg)
                                begin
                                    high_next = tick.adc_sample;
                                end
                            end
                            if (win_due)
                            begin
                                nres_next  = 1'b1;
                                phase_next = PH_WAIT;
                                idx_next   = PCT_CURRENT;
                                run_next   = 1'b0;
                                if (cnt_smp != '0)
                                begin
                                    div_req.start    = 1'b1;
                                    div_req.dividend = DIV_W'(sum_smp);
                                    div_req.divisor  = DEN_W'(cnt_smp);
                                    sum_next         = '0;
                                    cnt_next         = '0;
                                    power_next       = 1'b0;
                                    state_next       = S_AVG;
                                end
                                else
                                begin
                                    state_next = S_PCT;
                                end
                            end
                        end
                        default:
                        begin
                            wait_next = wait_due ? '0 : wait_sum[IVL_W-1:0];
                            if (wait_due)
                            begin
                                phase_next = PH_POLL;
                                power_next = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_AVG:
            begin
                if (div_rsp.done)
                begin
                    avg_next   = div_rsp.quotient[ADC_BITS-1:0];
                    state_next = S_PCT;
                end
            end
            S_PCT:
            begin
                if (!run_reg)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'(pct_op.num);
                    div_req.divisor  = DEN_W'(pct_op.den);
                    zero_next        = pct_op.zero;
                    run_next         = 1'b1;
                end
                else if (div_rsp.done)
                begin
                    pct_next[idx_reg] = zero_reg ? '0 : pct_sat(div_rsp.quotient);
                    run_next          = 1'b0;
                    if (idx_reg == PCT_DRIEST)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || report.ready)
                begin
                    out_valid_next = 1'b1;
                    out_power_next = power_reg;
                    out_nres_next  = nres_reg;
                    out_pct_next   = pct_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_BOOT;
            wait_reg      <= RESET_WAIT_ELAPSED;
            poll_reg      <= '0;
            win_reg       <= '0;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            last_reg      <= '0;
            avg_reg       <= '0;
            low_reg       <= RESET_LOWEST_RAW;
            high_reg      <= '0;
            power_reg     <= 1'b0;
            nres_reg      <= 1'b0;
            pct_reg       <= '{default: '0};
            idx_reg       <= '0;
            run_reg       <= 1'b0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            wait_reg      <= wait_next;
            poll_reg      <= poll_next;
            win_reg       <= win_next;
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            last_reg      <= last_next;
            avg_reg       <= avg_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            power_reg     <= power_next;
            nres_reg      <= nres_next;
            pct_reg       <= pct_next;
            idx_reg       <= idx_next;
            run_reg       <= run_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_power_reg <= out_power_next;
        out_nres_reg  <= out_nres_next;
        out_pct_reg   <= out_pct_next;
    end

    assign tick.ready          = (state_reg == S_IDLE);
    assign report.valid        = out_valid_reg;
    assign report.sensor_power = out_power_reg;
    assign report.new_result   = out_nres_reg;
    assign report.current_pct  = out_pct_reg[PCT_CURRENT];
    assign report.average_pct  = out_pct_reg[PCT_AVERAGE];
    assign report.wettest_pct  = out_pct_reg[PCT_WETTEST];
    assign report.driest_pct   = out_pct_reg[PCT_DRIEST];

    a_avg_has_divider: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_AVG) |-> (div_rsp.busy || div_rsp.done))
        else $error("waiting on the average with the divider idle");

    a_boot_once: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_BOOT) |=> (phase_reg != PH_BOOT))
        else $error("boot phase entered again");

    a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (sum_reg == '0))
        else $error("sample sum nonzero with no samples");

endmodule

// ----- rtl/mss_cfg_regs.sv -----
`timescale 1ns / 1ps

module mss_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [mss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mss_pkg::CFG_DATA_W-1:0] cfg_data,
    output mss_pkg::cfg_t                  cfg
);
    import mss_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_READING_INTERVAL: cfg_next.reading_interval = IVL_W'(cfg_data);
                REG_POLL_INTERVAL:    cfg_next.poll_interval    = IVL_W'(cfg_data);
                REG_WINDOW_LENGTH:    cfg_next.window_length    = IVL_W'(cfg_data);
                REG_DRY_RAW:          cfg_next.dry_raw          = CAL_W'(cfg_data);
                REG_WET_RAW:          cfg_next.wet_raw          = CAL_W'(cfg_data);
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reading_interval <= RESET_READING_INTERVAL;
            cfg_reg.poll_interval    <= RESET_POLL_INTERVAL;
            cfg_reg.window_length    <= RESET_WINDOW_LENGTH;
            cfg_reg.dry_raw          <= RESET_DRY_RAW;
            cfg_reg.wet_raw          <= RESET_WET_RAW;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/mss_divider.sv -----
`timescale 1ns / 1ps

module mss_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  mss_pkg::div_req_t req,
    output mss_pkg::div_rsp_t rsp
);
    import mss_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [DEN_W:0]       trial;
    logic [DEN_W:0]       diff;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_W);
            quo_next  = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_W-2:0], fits};
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider finished without running");

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != '0))
        else $error("divider busy with no steps left");

endmodule
